FILE: sv/pago_pkg.sv
`default_nettype none
package pago_pkg;

  // Fraction bits of the log and exp stages.
  localparam int LOG_FRAC = 24;

  // Exponent 0.190295 in Q.30 and the altitude scale in millimetres.
  localparam logic [31:0] EXP_Q30  = 32'd204327700;
  localparam logic [31:0] SCALE_MM = 32'd44330000;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ALREADY  = 3'd1;
  localparam logic [2:0] ST_PRESSURE = 3'd2;
  localparam logic [2:0] ST_GPS_POOR = 3'd3;
  localparam logic [2:0] ST_GPS_ZERO = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_QUERY_P0 = 3'd0;
  localparam logic [2:0] REG_CALIB_P0 = 3'd1;
  localparam logic [2:0] REG_MIN_CAL  = 3'd2;
  localparam logic [2:0] REG_MAX_CAL  = 3'd3;
  localparam logic [2:0] REG_MIN_FIX  = 3'd4;
  localparam logic [2:0] REG_MAX_PDOP = 3'd5;

  typedef logic [31:0] root_tab_t [LOG_FRAC];

  // Request from the top level to the power unit.
  typedef struct packed {
    logic        start;
    logic [16:0] p;
    logic [16:0] p0;
  } pago_req_t;

  // Response of the power unit.
  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] raw_mm;
  } pago_rsp_t;

  // Floor square root of a 64-bit word.
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] xv;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    xv    = x;
    for (int i = 0; i < 32; i++) begin
      if (xv >= res + bit_v) begin
        xv  = xv - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Roots 2^(2^-(i+1)) in Q.30, each the floor root of the one before.
  function automatic root_tab_t gen_roots();
    root_tab_t   tab;
    logic [63:0] root;
    root = 64'h8000_0000;
    for (int i = 0; i < LOG_FRAC; i++) begin
      root   = isqrt64(root << 30);
      tab[i] = root[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = gen_roots();

endpackage
`default_nettype wire

FILE: sv/pago_core.sv
`default_nettype none
module pago_core #(
  parameter int RATIO_FRAC_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pago_pkg::pago_req_t req,
  output pago_pkg::pago_rsp_t      rsp
);

  localparam int RW = RATIO_FRAC_BITS + 2;
  localparam int CW = $clog2(RW);
  localparam logic [RW-1:0] RMAX = '1;

  localparam logic [3:0] C_IDLE  = 4'd0;
  localparam logic [3:0] C_DIV   = 4'd1;
  localparam logic [3:0] C_NORM  = 4'd2;
  localparam logic [3:0] C_LMUL  = 4'd3;
  localparam logic [3:0] C_LUPD  = 4'd4;
  localparam logic [3:0] C_YMUL  = 4'd5;
  localparam logic [3:0] C_YUPD  = 4'd6;
  localparam logic [3:0] C_EBIT  = 4'd7;
  localparam logic [3:0] C_EMUL  = 4'd8;
  localparam logic [3:0] C_EUPD  = 4'd9;
  localparam logic [3:0] C_SHIFT = 4'd10;
  localparam logic [3:0] C_SMUL  = 4'd11;
  localparam logic [3:0] C_SUPD  = 4'd12;

  logic [3:0]         state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      s_r, s_nxt;
  logic [16:0]        rem_r, rem_nxt;
  logic [1:0]         plo_r, plo_nxt;
  logic [16:0]        p0_r, p0_nxt;
  logic [RW-1:0]      w_r, w_nxt;
  logic [30:0]        m_r, m_nxt;
  logic [23:0]        f_r, f_nxt;
  logic [7:0]         k_r, k_nxt;
  logic [23:0]        ef_r, ef_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic [33:0]        power_r, power_nxt;
  logic [63:0]        prod_r;
  logic signed [31:0] raw_r, raw_nxt;
  logic               done_r, done_nxt;

  // Shared multiplier operands.
  logic [31:0] mul_a, mul_b;

  // Division step signals.
  logic        div_bit;
  logic [17:0] div_t;
  logic        div_ge;
  logic [16:0] div_rem;
  logic [RW-1:0] div_q;

  // Normalized mantissa and log word.
  logic [RW+30:0] norm_tmp;
  logic [30:0]    norm_m;
  logic [7:0]     lg_ip;
  logic [31:0]    lg;
  logic [31:0]    lg_mag;
  logic [31:0]    sq;
  logic [63:0]    rnd_sum;
  logic [31:0]    y_mag, y;

  // Exp scaling and final altitude scaling.
  logic [7:0]         nk;
  logic [1:0]         lsh;
  logic signed [35:0] diff;
  logic [35:0]        dmag;
  logic [31:0]        raw_mag;

  always_comb begin
    div_bit = 1'b0;
    if (cnt_r == CW'(RATIO_FRAC_BITS + 1)) begin
      div_bit = plo_r[1];
    end else if (cnt_r == CW'(RATIO_FRAC_BITS)) begin
      div_bit = plo_r[0];
    end
    div_t   = {rem_r, div_bit};
    div_ge  = div_t >= {1'b0, p0_r};
    div_rem = div_ge ? 17'(div_t - {1'b0, p0_r}) : div_t[16:0];
    div_q   = {w_r[RW-2:0], div_ge};

    norm_tmp = {w_r, 31'b0};
    norm_m   = norm_tmp[RW+30 -: 31];

    // Integer part of log2 is one minus the normalizing shift.
    lg_ip  = 8'd1 - 8'(s_r);
    lg     = {lg_ip, f_r};
    lg_mag = lg[31] ? 32'(-lg) : lg;

    sq      = prod_r[61:30];
    rnd_sum = prod_r + 64'h2000_0000;
    y_mag   = rnd_sum[61:30];
    y       = lg[31] ? 32'(-y_mag) : y_mag;

    nk  = 8'(-k_r);
    lsh = (k_r >= 8'd2) ? 2'd2 : k_r[1:0];

    diff    = 36'sh4000_0000 - $signed({2'b0, power_r});
    dmag    = diff[35] ? 36'(-diff) : 36'(diff);
    raw_mag = rnd_sum[61:30];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      C_LMUL: begin
        mul_a = {1'b0, m_r};
        mul_b = {1'b0, m_r};
      end
      C_YMUL: begin
        mul_a = lg_mag;
        mul_b = pago_pkg::EXP_Q30;
      end
      C_EMUL: begin
        mul_a = acc_r;
        mul_b = pago_pkg::ROOT_TAB[cnt_r[4:0]];
      end
      C_SMUL: begin
        mul_a = dmag[31:0];
        mul_b = pago_pkg::SCALE_MM;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    s_nxt     = s_r;
    rem_nxt   = rem_r;
    plo_nxt   = plo_r;
    p0_nxt    = p0_r;
    w_nxt     = w_r;
    m_nxt     = m_r;
    f_nxt     = f_r;
    k_nxt     = k_r;
    ef_nxt    = ef_r;
    acc_nxt   = acc_r;
    power_nxt = power_r;
    raw_nxt   = raw_r;
    done_nxt  = 1'b0;
    case (state_r)
      C_IDLE: begin
        if (req.start) begin
          p0_nxt  = req.p0;
          plo_nxt = req.p[1:0];
          rem_nxt = {2'b0, req.p[16:2]};
          cnt_nxt = CW'(RW - 1);
          s_nxt   = '0;
          w_nxt   = '0;
          if (req.p == 17'd0) begin
            power_nxt = '0;
            state_nxt = C_SMUL;
          end else if (req.p0 == 17'd0 || {2'b0, req.p} >= {req.p0, 2'b0}) begin
            // The ratio saturates at just under four.
            w_nxt     = RMAX;
            state_nxt = C_NORM;
          end else begin
            state_nxt = C_DIV;
          end
        end
      end
      C_DIV: begin
        rem_nxt = div_rem;
        w_nxt   = div_q;
        if (cnt_r == '0) begin
          if (div_q == '0) begin
            power_nxt = '0;
            state_nxt = C_SMUL;
          end else begin
            state_nxt = C_NORM;
          end
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      C_NORM: begin
        if (w_r[RW-1]) begin
          m_nxt     = norm_m;
          f_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = C_LMUL;
        end else begin
          w_nxt = {w_r[RW-2:0], 1'b0};
          s_nxt = s_r + 1'b1;
        end
      end
      C_LMUL: begin
        state_nxt = C_LUPD;
      end
      C_LUPD: begin
        // One fraction bit of log2 per squaring.
        if (sq[31]) begin
          f_nxt = {f_r[22:0], 1'b1};
          m_nxt = sq[31:1];
        end else begin
          f_nxt = {f_r[22:0], 1'b0};
          m_nxt = sq[30:0];
        end
        if (cnt_r == CW'(pago_pkg::LOG_FRAC - 1)) begin
          state_nxt = C_YMUL;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = C_LMUL;
        end
      end
      C_YMUL: begin
        state_nxt = C_YUPD;
      end
      C_YUPD: begin
        k_nxt     = y[31:24];
        ef_nxt    = y[23:0];
        acc_nxt   = 32'h4000_0000;
        cnt_nxt   = '0;
        state_nxt = C_EBIT;
      end
      C_EBIT: begin
        if (ef_r[23]) begin
          state_nxt = C_EMUL;
        end else begin
          ef_nxt = {ef_r[22:0], 1'b0};
          if (cnt_r == CW'(pago_pkg::LOG_FRAC - 1)) begin
            state_nxt = C_SHIFT;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      C_EMUL: begin
        state_nxt = C_EUPD;
      end
      C_EUPD: begin
        acc_nxt = prod_r[61:30];
        ef_nxt  = {ef_r[22:0], 1'b0};
        if (cnt_r == CW'(pago_pkg::LOG_FRAC - 1)) begin
          state_nxt = C_SHIFT;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = C_EBIT;
        end
      end
      C_SHIFT: begin
        // Scale by two to the integer part of the exponent.
        if (!k_r[7] && k_r != 8'd0) begin
          power_nxt = {2'b0, acc_r} << lsh;
        end else if (nk >= 8'd34) begin
          power_nxt = '0;
        end else begin
          power_nxt = {2'b0, acc_r} >> nk;
        end
        state_nxt = C_SMUL;
      end
      C_SMUL: begin
        state_nxt = C_SUPD;
      end
      C_SUPD: begin
        raw_nxt   = diff[35] ? 32'(-raw_mag) : raw_mag;
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    s_r     <= s_nxt;
    rem_r   <= rem_nxt;
    plo_r   <= plo_nxt;
    p0_r    <= p0_nxt;
    w_r     <= w_nxt;
    m_r     <= m_nxt;
    f_r     <= f_nxt;
    k_r     <= k_nxt;
    ef_r    <= ef_nxt;
    acc_r   <= acc_nxt;
    power_r <= power_nxt;
    raw_r   <= raw_nxt;
    prod_r  <= mul_a * mul_b;
  end

  assign rsp.busy   = state_r != C_IDLE;
  assign rsp.done   = done_r;
  assign rsp.raw_mm = raw_r;

endmodule
`default_nettype wire

FILE: sv/pressure_altitude_gps_offset_top.sv
`default_nettype none
// Channel  Direction  Handshake                 Payload
// in_      slave      in_tvalid / in_tready     in_tdata (64), in_tuser (1)
// out_     master     out_tvalid / out_tready   out_tdata (32)
// cfg_     write      cfg_we                    cfg_index (3), cfg_wdata (17)
//
// Zero pressure skips to the scaling; a ratio that floors to zero runs the divide and
// scaling; a saturated ratio skips the divide; any other sample or passing calibration
// runs a 26-step divide, 1 to 26 normalize steps, 24 squarings, exp steps and scaling.
// A rejected calibration skips the power unit. in_tready is high only when idle. A
// finished result waits for the output register; a full one stalls the block.
// Reset is synchronous and active low; it restores configuration and control registers.
module pressure_altitude_gps_offset_top #(
  parameter int RATIO_FRAC_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // baro_pa[16:0], gps_fix_kind[19:17], gps_pdop[35:20], gps_altitude_mm[63:36]
  input  wire logic [63:0] in_tdata,
  // mode[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // altitude_mm[27:0], is_calibrated[28], status[31:29]
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_BUSY = 2'd1;
  localparam logic [1:0] T_POST = 2'd2;

  localparam logic signed [33:0] ALT_MAX = 34'sd100000000;
  localparam logic signed [33:0] ALT_MIN = -34'sd100000000;
  localparam logic signed [33:0] OFF_MAX = 34'sd2147483647;
  localparam logic signed [33:0] OFF_MIN = -34'sd2147483648;

  logic [16:0]        query_p0_r, calib_p0_r, min_cal_r, max_cal_r;
  logic [2:0]         min_fix_r;
  logic [15:0]        max_pdop_r;
  logic signed [31:0] offset_r, offset_nxt;
  logic               cal_r, cal_nxt;
  logic [1:0]         state_r, state_nxt;
  logic               mode_r, mode_nxt;
  logic signed [27:0] galt_r, galt_nxt;
  logic signed [27:0] pend_alt_r, pend_alt_nxt;
  logic [2:0]         pend_st_r, pend_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_data_r, out_data_nxt;

  logic               in_acc;
  logic               in_mode;
  logic [16:0]        in_p;
  logic [2:0]         in_fix;
  logic [15:0]        in_pdop;
  logic signed [27:0] in_galt;
  logic [2:0]         chk_st;
  logic               out_free;

  pago_pkg::pago_req_t core_req;
  pago_pkg::pago_rsp_t core_rsp;

  logic signed [33:0] alt_sum, off_diff;

  assign in_mode = in_tuser;
  assign in_p    = in_tdata[16:0];
  assign in_fix  = in_tdata[19:17];
  assign in_pdop = in_tdata[35:20];
  assign in_galt = $signed(in_tdata[63:36]);

  assign in_tready = state_r == T_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Calibration checks in priority order.
  always_comb begin
    if (cal_r) begin
      chk_st = pago_pkg::ST_ALREADY;
    end else if (in_p < min_cal_r || in_p > max_cal_r) begin
      chk_st = pago_pkg::ST_PRESSURE;
    end else if (in_fix < min_fix_r || in_pdop >= max_pdop_r) begin
      chk_st = pago_pkg::ST_GPS_POOR;
    end else if (in_galt == 28'sd0) begin
      chk_st = pago_pkg::ST_GPS_ZERO;
    end else begin
      chk_st = pago_pkg::ST_OK;
    end
  end

  always_comb begin
    core_req.start = in_acc && (!in_mode || chk_st == pago_pkg::ST_OK);
    core_req.p     = in_p;
    core_req.p0    = in_mode ? calib_p0_r : query_p0_r;
  end

  pago_core #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (core_req),
    .rsp  (core_rsp)
  );

  assign alt_sum  = 34'(core_rsp.raw_mm) + 34'(offset_r);
  assign off_diff = 34'(galt_r) - 34'(core_rsp.raw_mm);

  // Item control and result formation.
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    galt_nxt      = galt_r;
    pend_alt_nxt  = pend_alt_r;
    pend_st_nxt   = pend_st_r;
    offset_nxt    = offset_r;
    cal_nxt       = cal_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_mode;
          galt_nxt = in_galt;
          if (core_req.start) begin
            state_nxt = T_BUSY;
          end else begin
            pend_alt_nxt = '0;
            pend_st_nxt  = chk_st;
            state_nxt    = T_POST;
          end
        end
      end
      T_BUSY: begin
        if (core_rsp.done) begin
          pend_st_nxt = pago_pkg::ST_OK;
          if (!mode_r) begin
            if (alt_sum > ALT_MAX) begin
              pend_alt_nxt = 28'(ALT_MAX);
            end else if (alt_sum < ALT_MIN) begin
              pend_alt_nxt = 28'(ALT_MIN);
            end else begin
              pend_alt_nxt = 28'(alt_sum);
            end
          end else begin
            pend_alt_nxt = '0;
            cal_nxt      = 1'b1;
            if (off_diff > OFF_MAX) begin
              offset_nxt = 32'(OFF_MAX);
            end else if (off_diff < OFF_MIN) begin
              offset_nxt = 32'(OFF_MIN);
            end else begin
              offset_nxt = 32'(off_diff);
            end
          end
          state_nxt = T_POST;
        end
      end
      T_POST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {pend_st_r, cal_r, pend_alt_r};
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      cal_r       <= 1'b0;
      offset_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cal_r       <= cal_nxt;
      offset_r    <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    galt_r     <= galt_nxt;
    pend_alt_r <= pend_alt_nxt;
    pend_st_r  <= pend_st_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_p0_r <= 17'd101325;
      calib_p0_r <= 17'd101325;
      min_cal_r  <= 17'd70000;
      max_cal_r  <= 17'd120000;
      min_fix_r  <= 3'd3;
      max_pdop_r <= 16'd300;
    end else if (cfg_we) begin
      case (cfg_index)
        pago_pkg::REG_QUERY_P0: query_p0_r <= cfg_wdata;
        pago_pkg::REG_CALIB_P0: calib_p0_r <= cfg_wdata;
        pago_pkg::REG_MIN_CAL:  min_cal_r  <= cfg_wdata;
        pago_pkg::REG_MAX_CAL:  max_cal_r  <= cfg_wdata;
        pago_pkg::REG_MIN_FIX:  min_fix_r  <= cfg_wdata[2:0];
        pago_pkg::REG_MAX_PDOP: max_pdop_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The power unit finishes only while an item waits on it.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    core_rsp.done |-> state_r == T_BUSY)
    else $error("power unit finished with no item pending");

  // The power unit is idle whenever a new beat may be taken.
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !core_rsp.busy)
    else $error("input ready while the power unit is busy");

  // Once calibrated, the block stays calibrated.
  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r |=> cal_r)
    else $error("calibrated flag dropped");

  // A rejected attempt goes straight to the output stage.
  a_reject_post: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode && chk_st != pago_pkg::ST_OK) |=> state_r == T_POST)
    else $error("rejected attempt did not skip the computation");

  // A nonzero status carries a zero altitude.
  a_status_alt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[31:29] != pago_pkg::ST_OK) |-> out_tdata[27:0] == 28'd0)
    else $error("status result with nonzero altitude");

endmodule
`default_nettype wire

FILE: sim/pressure_altitude_gps_offset_top_tb.sv
`default_nettype none
module pressure_altitude_gps_offset_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 24;
  localparam longint ALT_MAX = 100000000;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_ITEMS = 1130;

  // Index with no register behind it.
  localparam logic [2:0] REG_UNMAPPED = 3'd6;

  // Wildcard status for rows whose status is left to the predictor.
  localparam logic [2:0] ST_ANY = 3'd7;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CALIB = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [16:0] p;
    logic [2:0]  fix;
    logic [15:0] pdop;
    logic signed [27:0] galt;
  } reading_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        cal;
    logic signed [27:0] alt;
  } altitude_t;

  // Directed row: a reading and, where obvious, its status.
  typedef struct packed {
    reading_t   rd;
    logic [2:0] want_status;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic [63:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tready = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_wdata = '0;
  wire in_tready;
  wire out_tvalid;
  wire [31:0] out_tdata;

  pressure_altitude_gps_offset_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow registers and state of the predictor.
  logic [16:0] query_p0, calib_p0, min_cal, max_cal;
  logic [2:0]  min_fix;
  logic [15:0] max_pdop;
  logic signed [31:0] offset_mm;
  logic        calibrated;

  altitude_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 0;
  bit stall_mode = 0;

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_q30(longint v);
    longint unsigned mag, q;
    mag = v < 0 ? -v : v;
    q = (mag + (64'd1 << 29)) >> 30;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  // (p/p0)^0.190295 in Q.30 through a log2/exp2 pair.
  function automatic longint unsigned pow_q30(logic [16:0] p, logic [16:0] p0);
    longint unsigned rmax, r, m, acc, root;
    int n;
    longint lg, y, k, f;
    rmax = (64'd1 << (FRAC + 2)) - 1;
    if (p == 0) return 0;
    if (p0 == 0) r = rmax;
    else begin
      r = (longint'(p) << FRAC) / p0;
      if (r > rmax) r = rmax;
    end
    if (r == 0) return 0;
    n = 0;
    while (n < 63 && (r >> (n + 1)) != 0) n++;
    m = n >= 30 ? r >> (n - 30) : r << (30 - n);
    f = 0;
    for (int i = 0; i < FRAC; i++) begin
      m = (m * m) >> 30;
      f <<= 1;
      if (m >= (64'd1 << 31)) begin
        f |= 1;
        m >>= 1;
      end
    end
    lg = longint'(n - FRAC) * (64'sd1 << FRAC) + f;
    y = round_q30(lg * 204327700);
    if (y >= 0) k = y / (64'sd1 << FRAC);
    else k = -((-y + (64'sd1 << FRAC) - 1) / (64'sd1 << FRAC));
    f = y - k * (64'sd1 << FRAC);
    acc = 64'd1 << 30;
    root = 64'd1 << 31;
    for (int i = 1; i <= FRAC; i++) begin
      root = sqrt_floor(root << 30);
      if ((f >> (FRAC - i)) & 1) acc = (acc * root) >> 30;
    end
    if (k > 0) begin
      if (k > 2) k = 2;
      acc <<= k;
    end else begin
      k = -k;
      acc = k > 63 ? 0 : acc >> k;
    end
    return acc;
  endfunction

  function automatic longint baro_mm(logic [16:0] p, logic [16:0] p0);
    return round_q30(((64'sd1 << 30) - longint'(pow_q30(p, p0))) * 44330000);
  endfunction

  // Expected result of one reading; updates the calibration state.
  function automatic altitude_t predict_altitude(reading_t rd);
    altitude_t res;
    longint a, off;
    res = '0;
    if (rd.mode == MODE_SAMPLE) begin
      a = baro_mm(rd.p, query_p0) + longint'(offset_mm);
      if (a > ALT_MAX) a = ALT_MAX;
      if (a < -ALT_MAX) a = -ALT_MAX;
      res.alt = a[27:0];
      res.status = pago_pkg::ST_OK;
    end else if (calibrated) res.status = pago_pkg::ST_ALREADY;
    else if (rd.p < min_cal || rd.p > max_cal) res.status = pago_pkg::ST_PRESSURE;
    else if (rd.fix < min_fix || rd.pdop >= max_pdop) res.status = pago_pkg::ST_GPS_POOR;
    else if (rd.galt == 0) res.status = pago_pkg::ST_GPS_ZERO;
    else begin
      off = longint'(rd.galt) - baro_mm(rd.p, calib_p0);
      if (off > 64'sd2147483647) off = 64'sd2147483647;
      if (off < -64'sd2147483648) off = -64'sd2147483648;
      offset_mm = off[31:0];
      calibrated = 1;
      res.status = pago_pkg::ST_OK;
    end
    res.cal = calibrated;
    return res;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      pago_pkg::REG_QUERY_P0: query_p0 = val;
      pago_pkg::REG_CALIB_P0: calib_p0 = val;
      pago_pkg::REG_MIN_CAL:  min_cal = val;
      pago_pkg::REG_MAX_CAL:  max_cal = val;
      pago_pkg::REG_MIN_FIX:  min_fix = val[2:0];
      pago_pkg::REG_MAX_PDOP: max_pdop = val[15:0];
      default: ;
    endcase
  endtask

  // Offer one beat, hold until taken, queue its prediction.
  task automatic send_reading(reading_t rd, logic [2:0] want);
    altitude_t e;
    in_tvalid <= 1;
    in_tuser <= rd.mode;
    in_tdata <= {rd.galt, rd.pdop, rd.fix, rd.p};
    do @(posedge clk); while (!in_tready);
    e = predict_altitude(rd);
    if (want != ST_ANY && want != e.status) begin
      $error("table status expected %0d predicted %0d", want, e.status);
      errors++;
    end
    expected_q.push_back(e);
  endtask

  task automatic idle_beat(int n);
    in_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle_beat(1);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Random reading; with good_cal set, a calibration reading draws its pressure, fix and PDOP
  // from the configured limits. Reset is applied once, so later phases may run calibrated.
  function automatic reading_t rand_reading(bit good_cal);
    reading_t rd;
    rd.mode = $urandom_range(0, 3) == 0;
    case ($urandom_range(0, 5))
      0: rd.p = 17'($urandom_range(0, 131071));
      1: rd.p = $urandom_range(0, 1) ? 17'd0 : 17'h1FFFF;
      default: rd.p = 17'($urandom_range(30000, 110000));
    endcase
    rd.fix = 3'($urandom_range(0, 7));
    rd.pdop = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535)) :
              16'($urandom_range(0, 400));
    rd.galt = $urandom_range(0, 7) == 0 ? 28'd0 :
              $urandom_range(0, 3) == 0 ? 28'(int'($urandom)) :
              28'(int'($urandom_range(0, 5000000)) - 2000000);
    if (good_cal && rd.mode == MODE_CALIB) begin
      rd.p = 17'($urandom_range(min_cal, max_cal));
      rd.fix = 3'($urandom_range(min_fix, 7));
      rd.pdop = max_pdop == 0 ? 16'd0 : 16'($urandom_range(0, max_pdop - 1));
    end
    return rd;
  endfunction

  row_t rows[] = '{
    '{'{MODE_SAMPLE, 17'd101325, 3'd0, 16'd0, 28'sd0}, pago_pkg::ST_OK},
    '{'{MODE_SAMPLE, 17'd0, 3'd0, 16'd0, 28'sd0}, pago_pkg::ST_OK},
    '{'{MODE_SAMPLE, 17'h1FFFF, 3'd7, 16'hFFFF, -28'sd1}, pago_pkg::ST_OK},
    '{'{MODE_SAMPLE, 17'd30000, 3'd0, 16'd0, 28'sd0}, pago_pkg::ST_OK},
    '{'{MODE_CALIB, 17'd69999, 3'd3, 16'd100, 28'sd5000}, pago_pkg::ST_PRESSURE},
    '{'{MODE_CALIB, 17'd120001, 3'd3, 16'd100, 28'sd5000}, pago_pkg::ST_PRESSURE},
    '{'{MODE_CALIB, 17'd100000, 3'd2, 16'd100, 28'sd5000}, pago_pkg::ST_GPS_POOR},
    '{'{MODE_CALIB, 17'd100000, 3'd3, 16'd300, 28'sd5000}, pago_pkg::ST_GPS_POOR},
    '{'{MODE_CALIB, 17'd100000, 3'd7, 16'd0, 28'sd0}, pago_pkg::ST_GPS_ZERO},
    '{'{MODE_CALIB, 17'd70000, 3'd3, 16'd299, 28'sd134217727}, pago_pkg::ST_OK},
    '{'{MODE_SAMPLE, 17'd0, 3'd0, 16'd0, 28'sd0}, pago_pkg::ST_OK},
    '{'{MODE_CALIB, 17'd100000, 3'd3, 16'd0, 28'sd5000}, pago_pkg::ST_ALREADY},
    '{'{MODE_SAMPLE, 17'd120000, 3'd0, 16'd0, -28'sd134217728}, pago_pkg::ST_OK}
  };

  // Receiver: random stalls, bursts of always-ready, and a long hold-off.
  initial begin
    out_tready <= 0;
    forever begin
      @(posedge clk);
      if (hold_off) out_tready <= 0;
      else if ($urandom_range(0, 99) < 3) stall_mode <= ~stall_mode;
      else out_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    altitude_t got, e;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (got.alt !== e.alt) begin
          $error("altitude_mm expected %0d actual %0d", e.alt, got.alt);
          errors++;
        end
        if (got.cal !== e.cal) begin
          $error("is_calibrated expected %0d actual %0d", e.cal, got.cal);
          errors++;
        end
        if (got.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, got.status);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int burst;
    reading_t rd;
    query_p0 = 17'd101325;
    calib_p0 = 17'd101325;
    min_cal = 17'd70000;
    max_cal = 17'd120000;
    min_fix = 3'd3;
    max_pdop = 16'd300;
    offset_mm = 0;
    calibrated = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed table.
    foreach (rows[i]) begin
      send_reading(rows[i].rd, rows[i].want_status);
      if ($urandom_range(0, 1)) idle_beat($urandom_range(1, 20));
    end
    drain();

    // Long receiver hold-off while the sender keeps offering.
    hold_off = 1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_reading(rand_reading(0), ST_ANY);
    join
    drain();

    // Random phases under several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(pago_pkg::REG_QUERY_P0, 17'd30000);
          write_reg(pago_pkg::REG_CALIB_P0, 17'h1FFFF);
        end
        1: begin
          write_reg(pago_pkg::REG_QUERY_P0, 17'd0);
          write_reg(pago_pkg::REG_MIN_CAL, 17'd0);
          write_reg(pago_pkg::REG_MAX_CAL, 17'h1FFFF);
        end
        2: begin
          write_reg(pago_pkg::REG_MIN_FIX, 17'd7);
          write_reg(pago_pkg::REG_MAX_PDOP, 17'hFFFF);
          write_reg(pago_pkg::REG_CALIB_P0, 17'd0);
        end
        3: begin
          write_reg(pago_pkg::REG_MIN_FIX, 17'd0);
          write_reg(pago_pkg::REG_MAX_PDOP, 17'd0);
          write_reg(pago_pkg::REG_QUERY_P0, 17'h1FFFF);
          write_reg(REG_UNMAPPED, 17'h1FFFF);
        end
        4: begin
          write_reg(pago_pkg::REG_MIN_CAL, 17'h1FFFF);
          write_reg(pago_pkg::REG_MAX_CAL, 17'd0);
          write_reg(pago_pkg::REG_QUERY_P0, 17'($urandom_range(30000, 131071)));
        end
        default: begin
          write_reg(pago_pkg::REG_QUERY_P0, 17'd101325);
          write_reg(pago_pkg::REG_CALIB_P0, 17'd101325);
          write_reg(pago_pkg::REG_MIN_CAL, 17'd70000);
          write_reg(pago_pkg::REG_MAX_CAL, 17'd120000);
          write_reg(pago_pkg::REG_MIN_FIX, 17'd3);
          write_reg(pago_pkg::REG_MAX_PDOP, 17'd300);
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 6; n += burst) begin
        burst = $urandom_range(1, 12);
        for (int j = 0; j < burst; j++) begin
          rd = rand_reading($urandom_range(0, 1));
          send_reading(rd, ST_ANY);
        end
        if ($urandom_range(0, 2) != 0) idle_beat($urandom_range(1, 30));
      end
      drain();
    end

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
